[src/sm4_block_cipher_macros.svh]
// Assertion macros shared by the SM4 block cipher checker.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef SM4_BLOCK_CIPHER_MACROS_SVH
`define SM4_BLOCK_CIPHER_MACROS_SVH

// Asserts a property on the clock with reset disable.
`define SM4_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Asserts that the consequent holds in the cycle after the antecedent.
`define SM4_ASSERT_NEXT(label, ante, cons, msg) \
	`SM4_ASSERT(label, (ante) |=> (cons), msg)

`endif

[src/sm4_pkg.sv]
// Types, constants and table functions of the SM4 block cipher.
// Used by the round unit and the top level; depends on nothing.
package sm4_pkg;

	typedef logic [31:0] word_t;
	typedef logic [3:0][31:0] quad_t;

	localparam logic [1:0] REG_KEY_HIGH = 2'd0;
	localparam logic [1:0] REG_KEY_LOW = 2'd1;
	localparam logic [1:0] REG_DECRYPT_MODE = 2'd2;

	localparam word_t FK_WORDS [4] = '{32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC};

	localparam logic [7:0] SBOX_TABLE [256] = '{
		8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
		8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
		8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
		8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
		8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
		8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
		8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
		8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
		8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
		8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
		8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
		8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
		8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
		8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
		8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
		8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
		8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
		8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
		8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
		8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
		8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
		8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
		8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
		8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
		8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
		8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
		8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
		8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
		8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
		8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
		8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
		8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
	};

	function automatic word_t rotl(input word_t v, input int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic word_t tau(input word_t v);
		word_t r;
		for (int b = 0; b < 4; b++) begin
			r[8*b +: 8] = SBOX_TABLE[v[8*b +: 8]];
		end
		return r;
	endfunction

	function automatic word_t ck_word(input logic [7:0] idx);
		word_t r;
		logic [7:0] b;
		r = '0;
		for (int j = 0; j < 4; j++) begin
			b = 8'((8'(idx << 2) + 8'(j)) * 8'd7);
			r = {r[23:0], b};
		end
		return r;
	endfunction

endpackage

[src/sm4_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Holds the expanded round keys; depends on nothing.
module sm4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/sm4_round.sv]
// Shared SM4 round unit, used for both key expansion and block rounds.
// Depends on sm4_pkg for the S-box, rotation and word types.
module sm4_round import sm4_pkg::*; (
	input  quad_t words,
	input  word_t rk,
	input  logic  key_sched,
	output word_t next_word
);

	word_t mix;
	word_t sub;
	word_t lin;

	always_comb begin
		mix = words[1] ^ words[2] ^ words[3] ^ rk;
		sub = tau(mix);
		if (key_sched) begin
			lin = sub ^ rotl(sub, 13) ^ rotl(sub, 23);
		end else begin
			lin = sub ^ rotl(sub, 2) ^ rotl(sub, 10) ^ rotl(sub, 18) ^ rotl(sub, 24);
		end
		next_word = words[0] ^ lin;
	end

endmodule

[src/sm4_block_cipher.sv]
// SM4 block cipher, 128-bit key and block, one shared round unit.
// The key and the direction are written through a plain register port
// (cfg_we, cfg_index, cfg_data); the user must write them only while the
// block is idle, as the block itself does not enforce this. An input
// transaction on in_valid/in_ready carries block_high/block_low; a result
// transaction on out_valid/out_ready carries result_high/result_low.
// After a key write the next block first expands the key through the
// round unit, filling all ROUND_COUNT entries of the round key RAM.
// A block then passes the load state, the ROUND_COUNT rounds of the run
// state (one round per cycle, limited by the single round unit and the RAM
// read port) and the done state, which moves it into the output register.
// in_ready is high only when idle, so no block is taken while one is busy.
// A result waits in the output register while out_ready is low; the block
// still accepts the next input and holds its finished words until the
// output register frees up.
// Reset clears the key to zero, selects encryption and marks the round
// keys as stale, so the first block always expands the key.
module sm4_block_cipher import sm4_pkg::*; #(
	parameter int ROUND_COUNT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_high,
	output logic [63:0] result_low
);

	localparam int CNT_W = $clog2(ROUND_COUNT);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(ROUND_COUNT - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_KEXP = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_RUN = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             keys_ready_q;
	logic             decrypt_q;
	logic [63:0]      key_high_q;
	logic [63:0]      key_low_q;
	logic             out_valid_q;
	quad_t            x_q;
	logic [63:0]      blk_high_q;
	logic [63:0]      blk_low_q;
	logic [63:0]      result_high_q;
	logic [63:0]      result_low_q;

	logic             kexp;
	logic             out_free;
	logic             accept;
	word_t            rk_data;
	word_t            round_key;
	word_t            next_word;
	logic [CNT_W-1:0] rd_base;
	logic [CNT_W-1:0] rd_addr;

	assign kexp = (state_q == ST_KEXP);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign round_key = kexp ? ck_word(8'(cnt_q)) : rk_data;
	assign rd_base = (state_q == ST_RUN) ? cnt_q + CNT_W'(1) : '0;
	assign rd_addr = decrypt_q ? LAST - rd_base : rd_base;

	sm4_round u_round (
		.words    (x_q),
		.rk       (round_key),
		.key_sched(kexp),
		.next_word(next_word)
	);

	sm4_ram #(
		.WIDTH(32),
		.DEPTH(ROUND_COUNT)
	) u_rk_ram (
		.clk  (clk),
		.we   (kexp),
		.waddr(cnt_q),
		.wdata(next_word),
		.raddr(rd_addr),
		.rdata(rk_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			keys_ready_q <= 1'b0;
			decrypt_q <= 1'b0;
			key_high_q <= '0;
			key_low_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_KEY_HIGH: begin
						key_high_q <= cfg_data;
						keys_ready_q <= 1'b0;
					end
					REG_KEY_LOW: begin
						key_low_q <= cfg_data;
						keys_ready_q <= 1'b0;
					end
					REG_DECRYPT_MODE: begin
						decrypt_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= keys_ready_q ? ST_LOAD : ST_KEXP;
					end
				end
				ST_KEXP: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == LAST) begin
						keys_ready_q <= 1'b1;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			blk_high_q <= block_high;
			blk_low_q <= block_low;
			x_q <= {key_low_q[31:0] ^ FK_WORDS[3], key_low_q[63:32] ^ FK_WORDS[2],
				key_high_q[31:0] ^ FK_WORDS[1], key_high_q[63:32] ^ FK_WORDS[0]};
		end else if (state_q == ST_LOAD) begin
			x_q <= {blk_low_q[31:0], blk_low_q[63:32], blk_high_q[31:0], blk_high_q[63:32]};
		end else if (state_q == ST_KEXP || state_q == ST_RUN) begin
			x_q <= {next_word, x_q[3], x_q[2], x_q[1]};
		end
		if (state_q == ST_DONE && out_free) begin
			result_high_q <= {x_q[3], x_q[2]};
			result_low_q <= {x_q[1], x_q[0]};
		end
	end

	assign out_valid = out_valid_q;
	assign result_high = result_high_q;
	assign result_low = result_low_q;

endmodule

[src/sm4_block_cipher_checker.sv]
// Port-level checker for the SM4 block cipher and its bind to the top level.
// Depends on sm4_block_cipher_macros.svh for the assertion macros.
`include "sm4_block_cipher_macros.svh"

module sm4_block_cipher_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] result_high,
	input logic [63:0] result_low
);

	logic         stall;
	logic [127:0] result_all;

	assign stall = out_valid && !out_ready;
	assign result_all = {result_high, result_low};

	// The block works on one transaction at a time and drops in_ready after accepting it.
	`SM4_ASSERT_NEXT(busy_after_in, in_valid && in_ready, !in_ready ##1 !in_ready, "early ready")

	`SM4_ASSERT_NEXT(no_instant_result, in_valid && in_ready, !$rose(out_valid), "early result")

	// A new result is posted only as the block returns to idle.
	`SM4_ASSERT(ready_with_result, $rose(out_valid) |-> in_ready, "result posted while busy")

	`SM4_ASSERT_NEXT(result_held, stall, out_valid && $stable(result_all), "result changed")

endmodule

bind sm4_block_cipher sm4_block_cipher_checker u_checker (.*);

[sim/tb_top.sv]
// Self-checking bench for the SM4 block cipher: directed vectors, then random
// blocks under changing keys and directions, checked against a local SM4 model.
// Depends on sm4_pkg and sm4_block_cipher from the source folder.
`timescale 1ns / 100ps

module tb_top;
	import sm4_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 80;
	localparam int ITEMS_PER_PHASE = 213;

	localparam logic [63:0] STD_PLAIN_HI = 64'h0123456789abcdef;
	localparam logic [63:0] STD_PLAIN_LO = 64'hfedcba9876543210;
	localparam logic [63:0] STD_CIPHER_HI = 64'h681edf34d206965e;
	localparam logic [63:0] STD_CIPHER_LO = 64'h86b3e94f536e4246;
	localparam logic [63:0] ALL_ONES = 64'hffffffffffffffff;
	localparam logic [63:0] ALL_ZEROS = 64'h0;

	localparam logic [0:255][7:0] SM4_SBOX = {
		128'hd690e9fecce13db716b614c228fb2c05, 128'h2b679a762abe04c3aa44132649860699,
		128'h9c4250f491ef987a33540b43edcfac62, 128'he4b31ca9c908e89580df94fa758f3fa6,
		128'h4707a7fcf37317ba83593c19e6854fa8, 128'h686b81b27164da8bf8eb0f4b70569d35,
		128'h1e240e5e6358d1a225227c3b01217887, 128'hd40046579fd327524c3602e7a0c4c89e,
		128'heabf8ad240c738b5a3f7f2cef96115a1, 128'he0ae5da49b341a55ad933230f58cb1e3,
		128'h1df6e22e8266ca60c02923ab0d534e6f, 128'hd5db3745defd8e2f03ff6a726d6c5b51,
		128'h8d1baf92bbddbc7f11d95c411f105ad8, 128'h0ac13188a5cd7bbd2d74d012b8e5b4b0,
		128'h8969974a0c96777e65b9f109c56ec684, 128'h18f07dec3adc4d2079ee5f3ed7cb3948
	};

	localparam logic [31:0] SM4_FK [4] = '{32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197,
		32'hB27022DC};

	typedef struct packed {
		logic        is_cfg;
		logic [1:0]  reg_idx;
		logic [63:0] data_hi;
		logic [63:0] data_lo;
		logic        typed;
		logic [63:0] exp_hi;
		logic [63:0] exp_lo;
	} stim_row_t;

	localparam int DIRECTED_COUNT = 23;
	localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		'{1'b0, REG_KEY_HIGH, ALL_ZEROS, ALL_ZEROS, 1'b0, ALL_ZEROS, ALL_ZEROS},
		'{1'b0, REG_KEY_HIGH, ALL_ONES, ALL_ONES, 1'b0, ALL_ZEROS, ALL_ZEROS},
		'{1'b1, REG_KEY_HIGH, STD_PLAIN_HI, ALL_ZEROS, 1'b0, ALL_ZEROS, ALL_ZEROS},
		'{1'b1, REG_KEY_LOW, STD_PLAIN_LO, ALL_ZEROS, 1'b0, ALL_ZEROS, ALL_ZEROS},
		'{1'b0, REG_KEY_HIGH, STD_PLAIN_HI, STD_PLAIN_LO, 1'b1, STD_CIPHER_HI,
			STD_CIPHER_LO},
		'{1'b1, REG_DECRYPT_MODE, 64'h1, ALL_ZEROS, 1'b0, ALL_ZEROS, ALL_ZEROS},
		'{1'b0, REG_KEY_HIGH, STD_CIPHER_HI, STD_CIPHER_LO, 1'b1, STD_PLAIN_HI,
			STD_PLAIN_LO},
		'{1'b1, REG_UNUSED, ALL_ONES, ALL_ZEROS, 1'b0, ALL_ZEROS, ALL_ZEROS},
		'{1'b0, REG_KEY_HIGH, STD_CIPHER_HI, STD_CIPHER_LO, 1'b1, STD_PLAIN_HI,
			STD_PLAIN_LO},
		'{1'b1, REG_DECRYPT_MODE, 64'hfffffffffffffffe, ALL_ZEROS, 1'b0, ALL_ZEROS,
			ALL_ZEROS},
		'{1'b0, REG_KEY_HIGH, STD_PLAIN_HI, STD_PLAIN_LO, 1'b1, STD_CIPHER_HI,
			STD_CIPHER_LO},
		'{1'b1, REG_KEY_LOW, ALL_ONES, ALL_ZEROS, 1'b0, ALL_ZEROS, ALL_ZEROS},
		'{1'b0, REG_KEY_HIGH, STD_PLAIN_HI, STD_PLAIN_LO, 1'b0, ALL_ZEROS, ALL_ZEROS},
		'{1'b1, REG_KEY_HIGH, ALL_ONES, ALL_ZEROS, 1'b0, ALL_ZEROS, ALL_ZEROS},
		'{1'b0, REG_KEY_HIGH, ALL_ZEROS, ALL_ZEROS, 1'b0, ALL_ZEROS, ALL_ZEROS},
		'{1'b0, REG_KEY_HIGH, ALL_ONES, ALL_ONES, 1'b0, ALL_ZEROS, ALL_ZEROS},
		'{1'b0, REG_KEY_HIGH, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0,
			ALL_ZEROS, ALL_ZEROS},
		'{1'b1, REG_DECRYPT_MODE, 64'h8000000000000001, ALL_ZEROS, 1'b0, ALL_ZEROS,
			ALL_ZEROS},
		'{1'b0, REG_KEY_HIGH, 64'h8000000000000000, 64'h1, 1'b0, ALL_ZEROS, ALL_ZEROS},
		'{1'b1, REG_KEY_HIGH, ALL_ZEROS, ALL_ZEROS, 1'b0, ALL_ZEROS, ALL_ZEROS},
		'{1'b1, REG_KEY_LOW, ALL_ZEROS, ALL_ZEROS, 1'b0, ALL_ZEROS, ALL_ZEROS},
		'{1'b0, REG_KEY_HIGH, ALL_ZEROS, ALL_ZEROS, 1'b0, ALL_ZEROS, ALL_ZEROS},
		'{1'b1, REG_DECRYPT_MODE, ALL_ZEROS, ALL_ZEROS, 1'b0, ALL_ZEROS, ALL_ZEROS}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] block_high;
	logic [63:0] block_low;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] result_high;
	logic [63:0] result_low;

	logic        row_typed;
	logic [63:0] row_exp_hi;
	logic [63:0] row_exp_lo;

	logic [63:0] cipher_key_hi;
	logic [63:0] cipher_key_lo;
	logic        decrypt_sel;
	logic [31:0] round_keys [32];
	logic        round_keys_valid;

	logic [127:0] pending_outputs [$];
	logic [127:0] predicted_block;
	logic [127:0] oldest_output;
	int error_count;
	int idle_cycles;
	int send_idle_pct;
	int recv_idle_pct;

	sm4_block_cipher u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.block_high(block_high),
		.block_low(block_low),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_high(result_high),
		.result_low(result_low)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		logic [31:0] r;
		for (int b = 0; b < 4; b++) begin
			r[8*b +: 8] = SM4_SBOX[w[8*b +: 8]];
		end
		return r;
	endfunction

	function automatic logic [31:0] mix_data(input logic [31:0] s);
		return s ^ {s[29:0], s[31:30]} ^ {s[21:0], s[31:22]} ^ {s[13:0], s[31:14]}
			^ {s[7:0], s[31:8]};
	endfunction

	function automatic logic [31:0] mix_key(input logic [31:0] s);
		return s ^ {s[18:0], s[31:19]} ^ {s[8:0], s[31:9]};
	endfunction

	function automatic void expand_round_keys();
		logic [31:0] k [4];
		logic [31:0] ck;
		logic [31:0] nk;
		k[0] = cipher_key_hi[63:32] ^ SM4_FK[0];
		k[1] = cipher_key_hi[31:0] ^ SM4_FK[1];
		k[2] = cipher_key_lo[63:32] ^ SM4_FK[2];
		k[3] = cipher_key_lo[31:0] ^ SM4_FK[3];
		for (int i = 0; i < 32; i++) begin
			for (int j = 0; j < 4; j++) begin
				ck[31 - 8*j -: 8] = 8'(((4 * i + j) * 7) & 255);
			end
			nk = k[0] ^ mix_key(sub_word(k[1] ^ k[2] ^ k[3] ^ ck));
			round_keys[i] = nk;
			k[0] = k[1];
			k[1] = k[2];
			k[2] = k[3];
			k[3] = nk;
		end
		round_keys_valid = 1'b1;
	endfunction

	function automatic logic [127:0] sm4_transform(input logic [63:0] hi, input logic [63:0] lo);
		logic [31:0] x [4];
		logic [31:0] rk;
		logic [31:0] nx;
		if (!round_keys_valid) begin
			expand_round_keys();
		end
		x[0] = hi[63:32];
		x[1] = hi[31:0];
		x[2] = lo[63:32];
		x[3] = lo[31:0];
		for (int i = 0; i < 32; i++) begin
			rk = decrypt_sel ? round_keys[31 - i] : round_keys[i];
			nx = x[0] ^ mix_data(sub_word(x[1] ^ x[2] ^ x[3] ^ rk));
			x[0] = x[1];
			x[1] = x[2];
			x[2] = x[3];
			x[3] = nx;
		end
		return {x[3], x[2], x[1], x[0]};
	endfunction

	function automatic void apply_reg_write(input logic [1:0] idx, input logic [63:0] value);
		case (idx)
			REG_KEY_HIGH: begin
				cipher_key_hi = value;
				round_keys_valid = 1'b0;
			end
			REG_KEY_LOW: begin
				cipher_key_lo = value;
				round_keys_valid = 1'b0;
			end
			REG_DECRYPT_MODE: begin
				decrypt_sel = value[0];
			end
			default: begin
			end
		endcase
	endfunction

	function automatic logic [63:0] random_field();
		case ($urandom_range(15))
			0: return ALL_ZEROS;
			1: return ALL_ONES;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
		wait_all_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		apply_reg_write(idx, value);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic offer_block(input logic [63:0] hi, input logic [63:0] lo, input logic typed,
		input logic [63:0] exp_hi, input logic [63:0] exp_lo);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		block_high <= hi;
		block_low <= lo;
		row_typed <= typed;
		row_exp_hi <= exp_hi;
		row_exp_lo <= exp_lo;
		do begin
			@(posedge clk);
		end while (!in_ready);
		@(negedge clk);
	endtask

	task automatic change_settings();
		logic [63:0] fill;
		wait_all_results();
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				write_reg(REG_KEY_HIGH, {$urandom, $urandom});
				write_reg(REG_KEY_LOW, {$urandom, $urandom});
			end
			4: begin
				write_reg(REG_KEY_LOW, {$urandom, $urandom});
			end
			5: begin
				write_reg(REG_KEY_HIGH, {$urandom, $urandom});
			end
			6: begin
				fill = $urandom_range(1) ? ALL_ONES : ALL_ZEROS;
				write_reg(REG_KEY_HIGH, fill);
				write_reg(REG_KEY_LOW, fill);
			end
			default: begin
			end
		endcase
		if ($urandom_range(1) == 1) begin
			write_reg(REG_DECRYPT_MODE, {$urandom, $urandom});
		end
		if ($urandom_range(7) == 0) begin
			write_reg(REG_UNUSED, {$urandom, $urandom});
		end
	endtask

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predicted_block = sm4_transform(block_high, block_low);
				if (row_typed) begin
					predicted_block = {row_exp_hi, row_exp_lo};
				end
				pending_outputs.push_back(predicted_block);
			end
			if (out_valid && out_ready) begin
				if (pending_outputs.size() == 0) begin
					$error("result_high: no transaction expected, actual %h", result_high);
					error_count++;
				end else begin
					oldest_output = pending_outputs.pop_front();
					if (result_high !== oldest_output[127:64]) begin
						$error("result_high: expected %h, actual %h", oldest_output[127:64],
							result_high);
						error_count++;
					end
					if (result_low !== oldest_output[63:0]) begin
						$error("result_low: expected %h, actual %h", oldest_output[63:0],
							result_low);
						error_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int sent;
		int group_size;
		stim_row_t row;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_KEY_HIGH;
		cfg_data = '0;
		in_valid = 1'b0;
		block_high = '0;
		block_low = '0;
		out_ready = 1'b0;
		row_typed = 1'b0;
		row_exp_hi = '0;
		row_exp_lo = '0;
		error_count = 0;
		idle_cycles = 0;
		send_idle_pct = 23;
		recv_idle_pct = 52;
		cipher_key_hi = '0;
		cipher_key_lo = '0;
		decrypt_sel = 1'b0;
		round_keys_valid = 1'b0;
		for (int i = 0; i < 32; i++) begin
			round_keys[i] = '0;
		end
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < DIRECTED_COUNT; r++) begin
			row = DIRECTED_ROWS[r];
			if (row.is_cfg) begin
				write_reg(row.reg_idx, row.data_hi);
			end else begin
				offer_block(row.data_hi, row.data_lo, row.typed, row.exp_hi, row.exp_lo);
			end
		end

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 52 : 0;
			recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 23 : 0;
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				change_settings();
				group_size = $urandom_range(5, 35);
				for (int k = 0; k < group_size && sent < ITEMS_PER_PHASE; k++) begin
					offer_block(random_field(), random_field(), 1'b0, ALL_ZEROS, ALL_ZEROS);
					sent++;
				end
			end
		end

		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_outputs.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[sm4_block_cipher.f]
+incdir+src
src/sm4_pkg.sv
src/sm4_ram.sv
src/sm4_round.sv
src/sm4_block_cipher.sv
src/sm4_block_cipher_checker.sv
sim/tb_top.sv
